### rtl/core/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Types and constants shared by the button debounce, hold and stuck block.
// ----------------------------------------------------------------------------
package bdh_pkg;

  localparam int unsigned NOW_WIDTH = 32;
  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_WIDTH-1:0] cfg_data_t;

  localparam cfg_index_t REG_DEBOUNCE_MS = 2'd0;
  localparam cfg_index_t REG_HOLD_DELAY = 2'd1;
  localparam cfg_index_t REG_STUCK_DELAY = 2'd2;

  localparam cfg_data_t DEBOUNCE_MS_RESET = 16'd30;
  localparam cfg_data_t HOLD_DELAY_RESET = 16'd300;
  localparam cfg_data_t STUCK_DELAY_RESET = 16'd2000;

  typedef struct packed {
    logic pin_level;
    logic [NOW_WIDTH-1:0] now_ms;
  } poll_item_t;

  typedef struct packed {
    logic press_pulse;
    logic toggle_state;
    logic held;
    logic stuck;
    logic latched;
  } result_item_t;

endpackage

### rtl/core/bdh_poll_if.sv
// ----------------------------------------------------------------------------
// bdh_poll_if
// Poll request channel: valid, ready and one pin sample with its time.
// ----------------------------------------------------------------------------
interface bdh_poll_if;
  logic valid;
  logic ready;
  bdh_pkg::poll_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bdh_result_if.sv
// ----------------------------------------------------------------------------
// bdh_result_if
// Result request channel: valid, ready and the button flags of one poll.
// ----------------------------------------------------------------------------
interface bdh_result_if;
  logic valid;
  logic ready;
  bdh_pkg::result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bdh_cfg_if.sv
// ----------------------------------------------------------------------------
// bdh_cfg_if
// Configuration write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface bdh_cfg_if;
  logic valid;
  logic ready;
  bdh_pkg::cfg_index_t index;
  bdh_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/button_debounce_hold_stuck_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_stuck_unit
// Debouncer for one active-low button with toggle, hold and stuck detection.
// A poll's result is registered and offered in the cycle after it is accepted.
// Throughput: one poll per cycle while results are taken (single state path).
// The result register frees itself when taken, so polls flow while results
// are read. Reset: flags and event time clear, registers take 30/300/2000.
// ----------------------------------------------------------------------------
module button_debounce_hold_stuck_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  bdh_cfg_if.sink cfg,
  bdh_poll_if.sink poll,
  bdh_result_if.source result
);

  typedef logic [TIME_WIDTH-1:0] time_t;

  bdh_pkg::cfg_data_t debounce_ms;
  bdh_pkg::cfg_data_t hold_delay;
  bdh_pkg::cfg_data_t stuck_delay;

  logic press_latch, press_latch_next;
  logic toggle_flag, toggle_flag_next;
  logic hold_flag, hold_flag_next;
  logic stuck_flag, stuck_flag_next;
  time_t event_time, event_time_next;

  logic result_valid;
  bdh_pkg::result_item_t result_data;
  bdh_pkg::result_item_t result_next;

  logic poll_accept;
  logic pressed;
  time_t now_t;
  time_t elapsed;
  logic over_debounce, over_hold, over_stuck;
  logic press_hit, release_hit, hold_hit, stuck_hit;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= bdh_pkg::DEBOUNCE_MS_RESET;
      hold_delay <= bdh_pkg::HOLD_DELAY_RESET;
      stuck_delay <= bdh_pkg::STUCK_DELAY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        bdh_pkg::REG_DEBOUNCE_MS: debounce_ms <= cfg.data;
        bdh_pkg::REG_HOLD_DELAY: hold_delay <= cfg.data;
        bdh_pkg::REG_STUCK_DELAY: stuck_delay <= cfg.data;
        default: ;
      endcase
    end
  end

  // align the 32-bit poll time to the internal time width
  generate
    if (TIME_WIDTH >= bdh_pkg::NOW_WIDTH) begin : g_time_ext
      assign now_t = time_t'(poll.data.now_ms);
    end else begin : g_time_cut
      assign now_t = poll.data.now_ms[TIME_WIDTH-1:0];
    end
  endgenerate

  assign poll.ready = !rst && (!result_valid || result.ready);
  assign poll_accept = poll.valid && poll.ready;

  assign pressed = !poll.data.pin_level;
  assign elapsed = now_t - event_time;
  assign over_debounce = elapsed > time_t'(debounce_ms);
  assign over_hold = elapsed > time_t'(hold_delay);
  assign over_stuck = elapsed > time_t'(stuck_delay);

  // a press restarts the timer, so hold and stuck cannot follow in that poll
  assign press_hit = pressed && !press_latch && over_debounce;
  assign release_hit = !pressed && over_debounce;
  assign hold_hit = pressed && press_latch && over_hold && !over_stuck;
  assign stuck_hit = pressed && press_latch && over_stuck;

  always_comb begin
    press_latch_next = press_latch;
    toggle_flag_next = toggle_flag;
    hold_flag_next = hold_flag;
    stuck_flag_next = stuck_flag;
    event_time_next = event_time;
    if (press_hit) begin
      toggle_flag_next = !toggle_flag;
      press_latch_next = 1'b1;
      event_time_next = now_t;
    end else if (release_hit) begin
      press_latch_next = 1'b0;
      hold_flag_next = 1'b0;
      stuck_flag_next = 1'b0;
      event_time_next = now_t;
    end else if (hold_hit) begin
      hold_flag_next = 1'b1;
      toggle_flag_next = !toggle_flag;
    end else if (stuck_hit) begin
      hold_flag_next = 1'b0;
      stuck_flag_next = 1'b1;
      toggle_flag_next = !toggle_flag;
    end
    result_next.press_pulse = press_hit;
    result_next.toggle_state = toggle_flag_next;
    result_next.held = hold_flag_next;
    result_next.stuck = stuck_flag_next;
    result_next.latched = press_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_latch <= 1'b0;
      toggle_flag <= 1'b0;
      hold_flag <= 1'b0;
      stuck_flag <= 1'b0;
      event_time <= '0;
      result_valid <= 1'b0;
    end else begin
      if (poll_accept) begin
        press_latch <= press_latch_next;
        toggle_flag <= toggle_flag_next;
        hold_flag <= hold_flag_next;
        stuck_flag <= stuck_flag_next;
        event_time <= event_time_next;
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_accept) begin
      result_data <= result_next;
    end
  end

  assign result.valid = result_valid;
  assign result.data = result_data;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button debounce, hold and stuck block. A
// tracker class predicts the flags of every accepted poll and compares them
// with the result channel. Directed polls walk the timing edges; random
// press and release bursts then run under several register settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam bdh_pkg::cfg_index_t REG_UNUSED = 2'd3;

  class button_tracker;
    bdh_pkg::cfg_data_t debounce;
    bdh_pkg::cfg_data_t hold_dly;
    bdh_pkg::cfg_data_t stuck_dly;
    logic latch;
    logic toggle;
    logic hold;
    logic stuck;
    logic [bdh_pkg::NOW_WIDTH-1:0] event_ms;
    bdh_pkg::result_item_t expected_flags[$];
    int errors;

    function new();
      debounce = bdh_pkg::DEBOUNCE_MS_RESET;
      hold_dly = bdh_pkg::HOLD_DELAY_RESET;
      stuck_dly = bdh_pkg::STUCK_DELAY_RESET;
      latch = 1'b0;
      toggle = 1'b0;
      hold = 1'b0;
      stuck = 1'b0;
      event_ms = '0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void set_reg(bdh_pkg::cfg_index_t idx, bdh_pkg::cfg_data_t val);
      case (idx)
        bdh_pkg::REG_DEBOUNCE_MS: debounce = val;
        bdh_pkg::REG_HOLD_DELAY: hold_dly = val;
        bdh_pkg::REG_STUCK_DELAY: stuck_dly = val;
        default: ;
      endcase
    endfunction

    function void note_poll(bdh_pkg::poll_item_t p);
      bdh_pkg::result_item_t r;
      logic pressed;
      logic [bdh_pkg::NOW_WIDTH-1:0] gap;
      r = '0;
      pressed = ~p.pin_level;
      gap = p.now_ms - event_ms;
      if (pressed && !latch && gap > debounce) begin
        toggle = ~toggle;
        latch = 1'b1;
        event_ms = p.now_ms;
        r.press_pulse = 1'b1;
      end
      gap = p.now_ms - event_ms;
      if (!pressed && gap > debounce) begin
        latch = 1'b0;
        hold = 1'b0;
        stuck = 1'b0;
        event_ms = p.now_ms;
      end
      gap = p.now_ms - event_ms;
      if (pressed && latch && gap > hold_dly && gap <= stuck_dly) begin
        hold = 1'b1;
        toggle = ~toggle;
      end
      gap = p.now_ms - event_ms;
      if (pressed && latch && gap > stuck_dly) begin
        hold = 1'b0;
        stuck = 1'b1;
        toggle = ~toggle;
      end
      r.toggle_state = toggle;
      r.held = hold;
      r.stuck = stuck;
      r.latched = latch;
      expected_flags.push_back(r);
    endfunction

    task compare_bit(string field, logic want, logic got);
      if (got !== want) begin
        report($sformatf("%s expected %0b got %0b", field, want, got));
      end
    endtask

    task check_result(bdh_pkg::result_item_t got);
      bdh_pkg::result_item_t want;
      if (expected_flags.size() == 0) begin
        report("result with no poll waiting");
      end else begin
        want = expected_flags.pop_front();
        compare_bit("press_pulse", want.press_pulse, got.press_pulse);
        compare_bit("toggle_state", want.toggle_state, got.toggle_state);
        compare_bit("held", want.held, got.held);
        compare_bit("stuck", want.stuck, got.stuck);
        compare_bit("latched", want.latched, got.latched);
      end
    endtask

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bdh_cfg_if cfg_ch ();
  bdh_poll_if poll_ch ();
  bdh_result_if res_ch ();

  button_debounce_hold_stuck_unit #(
    .TIME_WIDTH(bdh_pkg::NOW_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .poll(poll_ch),
    .result(res_ch)
  );

  button_tracker sb = new();

  int send_idle = 0;
  int recv_stall = 0;
  int polls_sent = 0;
  int hold_left;
  logic [7:0] stall_req = '0;
  logic [7:0] stall_seen;
  logic [bdh_pkg::NOW_WIDTH-1:0] cur_now;

  always #4 clk = ~clk;

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_seen <= '0;
      hold_left <= 0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left <= 400;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (poll_ch.valid && poll_ch.ready) sb.note_poll(poll_ch.data);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    end
  end

  task automatic write_reg(bdh_pkg::cfg_index_t idx, bdh_pkg::cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(bdh_pkg::cfg_data_t deb, bdh_pkg::cfg_data_t hld,
                           bdh_pkg::cfg_data_t stk, bit poke_unused);
    write_reg(bdh_pkg::REG_DEBOUNCE_MS, deb);
    write_reg(bdh_pkg::REG_HOLD_DELAY, hld);
    write_reg(bdh_pkg::REG_STUCK_DELAY, stk);
    if (poke_unused) write_reg(REG_UNUSED, bdh_pkg::cfg_data_t'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic poll_at(logic pin, logic [bdh_pkg::NOW_WIDTH-1:0] now);
    bdh_pkg::poll_item_t it;
    it.pin_level = pin;
    it.now_ms = now;
    while ($urandom_range(0, 99) < send_idle) begin
      poll_ch.valid <= 1'b0;
      @(posedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.data <= it;
    do @(posedge clk); while (!poll_ch.ready);
    polls_sent++;
  endtask

  task automatic drain();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic bdh_pkg::cfg_data_t pick_delay();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'hFFFF;
      2: return bdh_pkg::cfg_data_t'($urandom_range(0, 50));
      3: return bdh_pkg::cfg_data_t'($urandom_range(0, 500));
      default: return bdh_pkg::cfg_data_t'($urandom());
    endcase
  endfunction

  // one press or release burst, time steps scaled to the current delays
  task automatic random_burst();
    logic level;
    logic [bdh_pkg::NOW_WIDTH-1:0] step;
    int len;
    level = ($urandom_range(0, 99) < 60) ? 1'b0 : 1'b1;
    len = $urandom_range(1, 12);
    repeat (len) begin
      case ($urandom_range(0, 19))
        0: step = $urandom();
        1, 2, 3, 4: step = $urandom_range(0, 3);
        5, 6, 7, 8: step = $urandom_range(0, sb.debounce + 2);
        9, 10, 11, 12, 13: step = $urandom_range(0, sb.hold_dly / 3 + 2);
        default: step = $urandom_range(0, sb.stuck_dly / 4 + 2);
      endcase
      cur_now = cur_now + step;
      if ($urandom_range(0, 9) == 0) poll_at(~level, cur_now);
      else poll_at(level, cur_now);
    end
  endtask

  initial begin
    int target;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    poll_ch.valid <= 1'b0;
    poll_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset delays: bounce, press, hold window edges, stuck, release, wrap
    poll_at(1'b1, 32'd0);
    poll_at(1'b0, 32'd10);
    poll_at(1'b0, 32'd31);
    poll_at(1'b0, 32'd331);
    poll_at(1'b0, 32'd332);
    poll_at(1'b0, 32'd2031);
    poll_at(1'b0, 32'd2032);
    poll_at(1'b1, 32'd2040);
    poll_at(1'b0, 32'd2050);
    poll_at(1'b0, 32'hFFFF_FFF0);
    poll_at(1'b0, 32'h0000_0010);
    poll_at(1'b1, 32'h0000_0020);
    poll_at(1'b0, 32'hFFFF_FFFF);
    drain();

    // stuck delay below hold delay, zero debounce
    configure(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    poll_at(1'b0, 32'h100);
    poll_at(1'b1, 32'h100);
    poll_at(1'b1, 32'h100);
    poll_at(1'b0, 32'h101);
    poll_at(1'b0, 32'h101);
    drain();

    configure(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    poll_at(1'b1, 32'h102);
    poll_at(1'b0, 32'h103);
    poll_at(1'b0, 32'h1_0101);
    poll_at(1'b1, 32'h1_0102);
    poll_at(1'b0, 32'h1_0103);
    poll_at(1'b0, 32'h2_0103);
    cur_now = 32'h2_0103;
    drain();

    for (int round = 0; round < 2; round++) begin
      for (int mode = 0; mode < 4; mode++) begin
        configure(pick_delay(), pick_delay(), pick_delay(), $urandom_range(0, 3) == 0);
        send_idle = (mode == 1) ? 55 : (mode == 3) ? 29 : 0;
        recv_stall = (mode == 2) ? 55 : (mode == 3) ? 29 : 0;
        target = polls_sent + 135;
        if (round == 0 && mode == 0) begin
          while (polls_sent < target - 115) random_burst();
          stall_req <= stall_req + 8'd1;
        end
        while (polls_sent < target) random_burst();
        drain();
      end
    end

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/bdh_pkg.sv
rtl/core/bdh_poll_if.sv
rtl/core/bdh_result_if.sv
rtl/core/bdh_cfg_if.sv
rtl/core/button_debounce_hold_stuck_unit.sv
bench/tb_top.sv
